// ----- rtl/ppu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppu_pkg
// types, codes and constants of the particle pool update block
// ----------------------------------------------------------------------------
package ppu_pkg;

    localparam int POOL_SLOTS_DEF = 64;
    localparam int SLOT_W         = 6;
    localparam int POS_W          = 32;
    localparam int VEL_W          = 19;
    localparam int FAC_W          = 17;
    localparam int ALPHA_W        = 17;
    localparam int LIFE_W         = 16;
    localparam int PROD_W         = VEL_W + FAC_W + 1;
    localparam int S_DATA_W       = 192;
    localparam int M_DATA_W       = 152;
    localparam int ADDR_W         = 5;

    localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'd65536;

    // input kinds
    localparam logic KIND_SPAWN = 1'b0;
    localparam logic KIND_TICK  = 1'b1;

    // result kinds
    localparam logic [1:0] RK_SPAWN = 2'd0;
    localparam logic [1:0] RK_LIVE  = 2'd1;
    localparam logic [1:0] RK_EMPTY = 2'd2;

    // register indexes
    localparam logic [2:0] REG_INITIAL_LIFE = 3'd0;
    localparam logic [2:0] REG_FADE_WINDOW  = 3'd1;
    localparam logic [2:0] REG_FADE_STEP    = 3'd2;
    localparam logic [2:0] REG_DAMP_H       = 3'd3;
    localparam logic [2:0] REG_DAMP_V       = 3'd4;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN,
        ST_RESP,
        ST_CHECK,
        ST_MULX,
        ST_MULY,
        ST_MULZ,
        ST_UPD,
        ST_PUSH,
        ST_FINAL
    } state_t;

    typedef struct packed {
        logic [POS_W-1:0]   px;
        logic [POS_W-1:0]   py;
        logic [POS_W-1:0]   pz;
        logic [VEL_W-1:0]   vx;
        logic [VEL_W-1:0]   vy;
        logic [VEL_W-1:0]   vz;
        logic [POS_W-1:0]   size;
        logic [ALPHA_W-1:0] alpha;
        logic [LIFE_W-1:0]  life;
    } slot_rec_t;

    typedef struct packed {
        logic [1:0]         kind;
        logic               acc;
        logic [SLOT_W-1:0]  slot;
        logic [POS_W-1:0]   x;
        logic [POS_W-1:0]   y;
        logic [POS_W-1:0]   z;
        logic [POS_W-1:0]   size;
        logic [ALPHA_W-1:0] alpha;
    } result_t;

    // position plus velocity, saturated to the signed 32-bit range
    function automatic logic [POS_W-1:0] sat_add(logic [POS_W-1:0] p, logic [VEL_W-1:0] v);
        logic [POS_W:0] s;
        s = {p[POS_W-1], p} + {{(POS_W+1-VEL_W){v[VEL_W-1]}}, v};
        if (s[POS_W] != s[POS_W-1])
            sat_add = s[POS_W] ? {1'b1, {(POS_W-1){1'b0}}} : {1'b0, {(POS_W-1){1'b1}}};
        else
            sat_add = s[POS_W-1:0];
    endfunction

endpackage
`default_nettype wire

// ----- rtl/particle_pool_update.sv -----
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// particle_pool_update
// fixed pool of particles with spawn and per-tick physics update
// ----------------------------------------------------------------------------
// A spawn transfer (tuser 0) scans the live flags one slot a cycle, takes the
// lowest free slot and answers with one result, which waits out any output
// stall. A tick transfer (tuser 1) walks every slot in ascending order; a free
// slot is skipped, and a live slot goes through memory read, three passes of the
// one shared 19x18 multiplier for the damping, update and write-back, and
// report. Each surviving particle gives one result; tlast marks the final
// one, and a tick with no survivors gives a single empty result. The block
// takes no input while an item is in work. Slot state is kept in one memory
// of POOL_SLOTS words; live flags are flip-flops cleared by reset, so no
// clearing pass. Velocities are kept 19 bits wide, so damping must be at most
// 1.0 and never amplify them; the block itself does not enforce this.
// ----------------------------------------------------------------------------
module particle_pool_update #(
    parameter int POOL_SLOTS = ppu_pkg::POOL_SLOTS_DEF
) (
    input  wire logic                          clk,
    input  wire logic                          rst_n,
    // config port
    input  wire logic                          psel,
    input  wire logic                          penable,
    input  wire logic                          pwrite,
    input  wire logic [ppu_pkg::ADDR_W-1:0]    paddr,
    input  wire logic [31:0]                   pwdata,
    output logic      [31:0]                   prdata,
    output logic                               pready,
    // input stream
    input  wire logic                          s_axis_tvalid,
    output logic                               s_axis_tready,
    // spawn_x, spawn_y, spawn_z, spawn_size, start_vx, start_vy, start_vz, zero pad
    input  wire logic [ppu_pkg::S_DATA_W-1:0]  s_axis_tdata,
    // kind
    input  wire logic                          s_axis_tuser,
    // result stream
    output logic                               m_axis_tvalid,
    input  wire logic                          m_axis_tready,
    // accepted, slot, out_x, out_y, out_z, out_size, out_alpha
    output logic      [ppu_pkg::M_DATA_W-1:0]  m_axis_tdata,
    // result_kind
    output logic      [1:0]                    m_axis_tuser,
    output logic                               m_axis_tlast
);

    localparam int CNT_W = ppu_pkg::SLOT_W + 1;
    localparam logic [CNT_W-1:0] CNT_END = CNT_W'(POOL_SLOTS);

    // configuration registers
    logic [ppu_pkg::LIFE_W-1:0]  init_life_reg;
    logic [ppu_pkg::LIFE_W-1:0]  fade_win_reg;
    logic [ppu_pkg::FAC_W-1:0]   fade_step_reg;
    logic [ppu_pkg::FAC_W-1:0]   damp_h_reg;
    logic [ppu_pkg::FAC_W-1:0]   damp_v_reg;

    logic cfg_wr;
    assign cfg_wr = psel && penable && pwrite;
    assign pready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            init_life_reg <= 16'd180;
            fade_win_reg  <= 16'd20;
            fade_step_reg <= 17'd3277;
            damp_h_reg    <= 17'd62259;
            damp_v_reg    <= 17'd64225;
        end
        else if (cfg_wr)
        begin
            case (paddr[4:2])
                ppu_pkg::REG_INITIAL_LIFE: init_life_reg <= pwdata[15:0];
                ppu_pkg::REG_FADE_WINDOW:  fade_win_reg  <= pwdata[15:0];
                ppu_pkg::REG_FADE_STEP:    fade_step_reg <= pwdata[16:0];
                ppu_pkg::REG_DAMP_H:       damp_h_reg    <= pwdata[16:0];
                ppu_pkg::REG_DAMP_V:       damp_v_reg    <= pwdata[16:0];
                default: ;
            endcase
        end
    end

    always_comb
    begin
        case (paddr[4:2])
            ppu_pkg::REG_INITIAL_LIFE: prdata = {16'd0, init_life_reg};
            ppu_pkg::REG_FADE_WINDOW:  prdata = {16'd0, fade_win_reg};
            ppu_pkg::REG_FADE_STEP:    prdata = {15'd0, fade_step_reg};
            ppu_pkg::REG_DAMP_H:       prdata = {15'd0, damp_h_reg};
            ppu_pkg::REG_DAMP_V:       prdata = {15'd0, damp_v_reg};
            default:                   prdata = 32'd0;
        endcase
    end

    // sequencer state
    ppu_pkg::state_t state_reg, state_next;
    logic [CNT_W-1:0]          idx_reg;
    logic [ppu_pkg::SLOT_W-1:0] idx;
    logic [POOL_SLOTS-1:0]     live_reg;
    logic                      found_reg;
    logic                      pend_valid_reg;
    logic                      survive_reg;
    logic                      out_valid_reg;

    assign idx = idx_reg[ppu_pkg::SLOT_W-1:0];

    // spawn payload held from the input transfer
    ppu_pkg::slot_rec_t spawn_reg;

    // slot memory, registered read
    ppu_pkg::slot_rec_t mem [POOL_SLOTS];
    ppu_pkg::slot_rec_t rd_reg;
    ppu_pkg::slot_rec_t wr_data;

    // shared multiplier
    logic signed [ppu_pkg::VEL_W-1:0]  mul_a;
    logic signed [ppu_pkg::FAC_W:0]    mul_b;
    logic        [ppu_pkg::PROD_W-1:0] prod_reg;
    logic        [ppu_pkg::VEL_W-1:0]  vx_new_reg, vy_new_reg, vz_new;

    ppu_pkg::result_t pend_reg, cand_reg, out_reg, cand_next;
    ppu_pkg::result_t resp_rec, empty_rec;
    logic             out_last_reg;

    // control strobes
    logic s_take, out_free, out_load, pend_load, mem_we, idx_inc, cur_live;
    logic at_end;

    assign out_free = !out_valid_reg || m_axis_tready;
    assign s_take   = s_axis_tvalid && s_axis_tready;
    assign at_end   = (idx_reg == CNT_END);
    assign cur_live = live_reg[idx];

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ppu_pkg::ST_IDLE:
                if (s_take)
                    state_next = (s_axis_tuser == ppu_pkg::KIND_TICK) ?
                                 ppu_pkg::ST_CHECK : ppu_pkg::ST_SCAN;
            ppu_pkg::ST_SCAN:
                if (at_end || !cur_live)
                    state_next = ppu_pkg::ST_RESP;
            ppu_pkg::ST_RESP:
                if (out_free)
                    state_next = ppu_pkg::ST_IDLE;
            ppu_pkg::ST_CHECK:
                if (at_end)
                    state_next = ppu_pkg::ST_FINAL;
                else if (cur_live)
                    state_next = ppu_pkg::ST_MULX;
            ppu_pkg::ST_MULX: state_next = ppu_pkg::ST_MULY;
            ppu_pkg::ST_MULY: state_next = ppu_pkg::ST_MULZ;
            ppu_pkg::ST_MULZ: state_next = ppu_pkg::ST_UPD;
            ppu_pkg::ST_UPD:  state_next = ppu_pkg::ST_PUSH;
            ppu_pkg::ST_PUSH:
                if (!survive_reg || pend_load)
                    state_next = ppu_pkg::ST_CHECK;
            ppu_pkg::ST_FINAL:
                if (out_free)
                    state_next = ppu_pkg::ST_IDLE;
            default: state_next = ppu_pkg::ST_IDLE;
        endcase
    end

    // strobes and multiplier operands
    always_comb
    begin
        s_axis_tready = 1'b0;
        out_load      = 1'b0;
        pend_load     = 1'b0;
        mem_we        = 1'b0;
        idx_inc       = 1'b0;
        mul_a         = $signed(rd_reg.vx);
        mul_b         = $signed({1'b0, damp_h_reg});
        case (state_reg)
            ppu_pkg::ST_IDLE:  s_axis_tready = 1'b1;
            ppu_pkg::ST_SCAN:
                if (!at_end)
                begin
                    mem_we  = !cur_live;
                    idx_inc = cur_live;
                end
            ppu_pkg::ST_RESP:  out_load = out_free;
            ppu_pkg::ST_CHECK: idx_inc = !at_end && !cur_live;
            ppu_pkg::ST_MULY:
            begin
                mul_a = $signed(rd_reg.vy);
                mul_b = $signed({1'b0, damp_v_reg});
            end
            ppu_pkg::ST_MULZ: mul_a = $signed(rd_reg.vz);
            ppu_pkg::ST_UPD:  mem_we = 1'b1;
            ppu_pkg::ST_PUSH:
            begin
                if (!survive_reg)
                    idx_inc = 1'b1;
                else
                begin
                    pend_load = !pend_valid_reg || out_free;
                    out_load  = pend_valid_reg && out_free;
                    idx_inc   = pend_load;
                end
            end
            ppu_pkg::ST_FINAL: out_load = out_free;
            default: ;
        endcase
    end

    // slot update datapath
    logic [ppu_pkg::ALPHA_W-1:0] alpha_new;
    logic [ppu_pkg::LIFE_W-1:0]  life_new;
    logic                        survive_next;
    ppu_pkg::slot_rec_t          upd_rec;

    assign vz_new = prod_reg[ppu_pkg::VEL_W+15:16];

    always_comb
    begin
        alpha_new = rd_reg.alpha;
        if (rd_reg.life < fade_win_reg)
            alpha_new = (rd_reg.alpha > fade_step_reg) ? rd_reg.alpha - fade_step_reg : '0;
        survive_next = (rd_reg.life > 16'd1);
        life_new     = survive_next ? rd_reg.life - 16'd1 : '0;
        upd_rec.px    = ppu_pkg::sat_add(rd_reg.px, vx_new_reg);
        upd_rec.py    = ppu_pkg::sat_add(rd_reg.py, vy_new_reg);
        upd_rec.pz    = ppu_pkg::sat_add(rd_reg.pz, vz_new);
        upd_rec.vx    = vx_new_reg;
        upd_rec.vy    = vy_new_reg;
        upd_rec.vz    = vz_new;
        upd_rec.size  = rd_reg.size;
        upd_rec.alpha = alpha_new;
        upd_rec.life  = life_new;
        wr_data = (state_reg == ppu_pkg::ST_UPD) ? upd_rec : spawn_reg;
        cand_next.kind  = ppu_pkg::RK_LIVE;
        cand_next.acc   = 1'b0;
        cand_next.slot  = idx;
        cand_next.x     = upd_rec.px;
        cand_next.y     = upd_rec.py;
        cand_next.z     = upd_rec.pz;
        cand_next.size  = rd_reg.size;
        cand_next.alpha = alpha_new;
        // spawn answer and empty tick answer
        resp_rec      = '0;
        resp_rec.kind = ppu_pkg::RK_SPAWN;
        resp_rec.acc  = found_reg;
        resp_rec.slot = found_reg ? idx : '0;
        empty_rec      = '0;
        empty_rec.kind = ppu_pkg::RK_EMPTY;
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
            mem[idx] <= wr_data;
        if (state_reg == ppu_pkg::ST_CHECK)
            rd_reg <= mem[idx];
    end

    // control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ppu_pkg::ST_IDLE;
            idx_reg        <= '0;
            live_reg       <= '0;
            found_reg      <= 1'b0;
            pend_valid_reg <= 1'b0;
            survive_reg    <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            if (s_take)
                idx_reg <= '0;
            else if (idx_inc)
                idx_reg <= idx_reg + 1'b1;
            if (state_reg == ppu_pkg::ST_SCAN)
                found_reg <= !at_end;
            // spawn marks the slot live, an expiring particle frees it
            if (state_reg == ppu_pkg::ST_SCAN && mem_we)
                live_reg[idx] <= 1'b1;
            if (state_reg == ppu_pkg::ST_UPD && !survive_next)
                live_reg[idx] <= 1'b0;
            if (state_reg == ppu_pkg::ST_UPD)
                survive_reg <= survive_next;
            if (pend_load)
                pend_valid_reg <= 1'b1;
            else if (state_reg == ppu_pkg::ST_FINAL && out_free)
                pend_valid_reg <= 1'b0;
            if (out_load)
                out_valid_reg <= 1'b1;
            else if (m_axis_tready)
                out_valid_reg <= 1'b0;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (s_take)
        begin
            spawn_reg.px    <= s_axis_tdata[31:0];
            spawn_reg.py    <= s_axis_tdata[63:32];
            spawn_reg.pz    <= s_axis_tdata[95:64];
            spawn_reg.size  <= s_axis_tdata[127:96];
            spawn_reg.vx    <= s_axis_tdata[146:128];
            spawn_reg.vy    <= s_axis_tdata[165:147];
            spawn_reg.vz    <= s_axis_tdata[184:166];
            spawn_reg.alpha <= ppu_pkg::ALPHA_ONE;
            spawn_reg.life  <= init_life_reg;
        end
        // one multiplier pass per axis; the floor of the damped value is the
        // arithmetic shift of the product
        prod_reg <= ppu_pkg::PROD_W'(mul_a * mul_b);
        if (state_reg == ppu_pkg::ST_MULY)
            vx_new_reg <= prod_reg[ppu_pkg::VEL_W+15:16];
        if (state_reg == ppu_pkg::ST_MULZ)
            vy_new_reg <= prod_reg[ppu_pkg::VEL_W+15:16];
        if (state_reg == ppu_pkg::ST_UPD)
            cand_reg <= cand_next;
        if (pend_load)
            pend_reg <= cand_reg;
        if (out_load)
        begin
            case (state_reg)
                ppu_pkg::ST_RESP:
                begin
                    out_reg      <= resp_rec;
                    out_last_reg <= 1'b1;
                end
                ppu_pkg::ST_PUSH:
                begin
                    out_reg      <= pend_reg;
                    out_last_reg <= 1'b0;
                end
                default:
                begin
                    // end of a tick: the held survivor is the final one
                    out_reg      <= pend_valid_reg ? pend_reg : empty_rec;
                    out_last_reg <= 1'b1;
                end
            endcase
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = out_reg.kind;
    assign m_axis_tlast  = out_last_reg;
    assign m_axis_tdata  = {out_reg.alpha, out_reg.size, out_reg.z, out_reg.y,
                            out_reg.x, out_reg.slot, out_reg.acc};

endmodule
`default_nettype wire

// ----- test/tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the particle pool update block
// ----------------------------------------------------------------------------
// Spawn and tick transfers go in on the input stream. Each accepted transfer
// is also handed to a scoreboard. The scoreboard keeps its own copy of the
// pool and the registers, and queues the results it expects. Results from the
// block are compared field by field with the oldest entry in that queue.
// Register settings change between phases, only while the block is idle.
// ----------------------------------------------------------------------------
module tb;

    localparam int NSLOTS      = 64;
    localparam int QUIET_LIMIT = 20000;
    localparam int LONG_HOLD   = 300;

    // one result of the block, as the scoreboard predicts it
    typedef struct {
        logic [1:0]  kind;
        logic        acc;
        logic [5:0]  slot;
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] size;
        logic [16:0] alpha;
        logic        last;
    } pool_result_t;

    // ------------------------------------------------------------------------
    // scoreboard: private copy of the pool, queue of predicted results
    // ------------------------------------------------------------------------
    class pool_scoreboard;
        int unsigned life_init, fade_win, fade_dec, damp_xz, damp_y;
        bit          live [NSLOTS];
        int          pos_x [NSLOTS], pos_y [NSLOTS], pos_z [NSLOTS];
        int          vel_x [NSLOTS], vel_y [NSLOTS], vel_z [NSLOTS];
        int unsigned psize [NSLOTS], alpha [NSLOTS], life [NSLOTS];
        pool_result_t pending [$];
        int          errors, results_seen, spawns_ok, spawns_full, empty_ticks;

        function void clear_pool();
            life_init = 180;
            fade_win  = 20;
            fade_dec  = 3277;
            damp_xz   = 62259;
            damp_y    = 64225;
            foreach (live[i])
                live[i] = 1'b0;
        endfunction

        function void write_reg(logic [2:0] idx, logic [31:0] value);
            case (idx)
                ppu_pkg::REG_INITIAL_LIFE: life_init = value[15:0];
                ppu_pkg::REG_FADE_WINDOW:  fade_win  = value[15:0];
                ppu_pkg::REG_FADE_STEP:    fade_dec  = value[16:0];
                ppu_pkg::REG_DAMP_H:       damp_xz   = value[16:0];
                ppu_pkg::REG_DAMP_V:       damp_y    = value[16:0];
                default: ;
            endcase
        endfunction

        function int clamp32(longint v);
            if (v > 64'sd2147483647)
                return 32'h7fffffff;
            if (v < -64'sd2147483648)
                return 32'h80000000;
            return int'(v);
        endfunction

        // floor of the exact product, arithmetic shift floors for negatives too
        function int damped(int v, int unsigned factor);
            longint p;
            p = longint'(v) * longint'(factor);
            return clamp32(p >>> 16);
        endfunction

        function void push_result(logic [1:0] kind, logic acc, int slot, int x, int y,
                                  int z, int unsigned sz, int unsigned al, logic last);
            pool_result_t r;
            r.kind = kind;  r.acc = acc;  r.slot = slot[5:0];
            r.x = x;  r.y = y;  r.z = z;  r.size = sz;  r.alpha = al[16:0];
            r.last = last;
            pending.push_back(r);
        endfunction

        function void note_item(logic kind, logic [ppu_pkg::S_DATA_W-1:0] d);
            int n;
            if (kind == ppu_pkg::KIND_SPAWN) begin
                for (int i = 0; i < NSLOTS; i++) begin
                    if (!live[i]) begin
                        live[i]  = 1'b1;
                        pos_x[i] = d[31:0];
                        pos_y[i] = d[63:32];
                        pos_z[i] = d[95:64];
                        psize[i] = d[127:96];
                        vel_x[i] = $signed(d[146:128]);
                        vel_y[i] = $signed(d[165:147]);
                        vel_z[i] = $signed(d[184:166]);
                        alpha[i] = 65536;
                        life[i]  = life_init;
                        spawns_ok++;
                        push_result(ppu_pkg::RK_SPAWN, 1'b1, i, 0, 0, 0, 0, 0, 1'b1);
                        return;
                    end
                end
                spawns_full++;
                push_result(ppu_pkg::RK_SPAWN, 1'b0, 0, 0, 0, 0, 0, 0, 1'b1);
                return;
            end
            n = 0;
            for (int i = 0; i < NSLOTS; i++) begin
                if (!live[i])
                    continue;
                vel_x[i] = damped(vel_x[i], damp_xz);
                vel_y[i] = damped(vel_y[i], damp_y);
                vel_z[i] = damped(vel_z[i], damp_xz);
                pos_x[i] = clamp32(longint'(pos_x[i]) + vel_x[i]);
                pos_y[i] = clamp32(longint'(pos_y[i]) + vel_y[i]);
                pos_z[i] = clamp32(longint'(pos_z[i]) + vel_z[i]);
                if (life[i] < fade_win)
                    alpha[i] = (alpha[i] > fade_dec) ? alpha[i] - fade_dec : 0;
                if (life[i] <= 1) begin
                    life[i] = 0;
                    live[i] = 1'b0;
                    continue;
                end
                life[i]--;
                push_result(ppu_pkg::RK_LIVE, 1'b0, i, pos_x[i], pos_y[i], pos_z[i],
                            psize[i], alpha[i], 1'b0);
                n++;
            end
            if (n == 0) begin
                empty_ticks++;
                push_result(ppu_pkg::RK_EMPTY, 1'b0, 0, 0, 0, 0, 0, 0, 1'b1);
            end
            else
                pending[$].last = 1'b1;
        endfunction

        function void field_cmp(string name, logic [31:0] want, logic [31:0] got);
            if (want !== got) begin
                errors++;
                $display("%0t mismatch %s: expected %h actual %h", $time, name, want, got);
            end
        endfunction

        function void check_result(logic [1:0] kind, logic [ppu_pkg::M_DATA_W-1:0] d,
                                   logic last);
            pool_result_t e;
            results_seen++;
            if (pending.size() == 0) begin
                errors++;
                $display("%0t unexpected result: expected none actual kind %0d data %h",
                         $time, kind, d);
                return;
            end
            e = pending.pop_front();
            field_cmp("result_kind", e.kind,  kind);
            field_cmp("accepted",    e.acc,   d[0]);
            field_cmp("slot",        e.slot,  d[6:1]);
            field_cmp("out_x",       e.x,     d[38:7]);
            field_cmp("out_y",       e.y,     d[70:39]);
            field_cmp("out_z",       e.z,     d[102:71]);
            field_cmp("out_size",    e.size,  d[134:103]);
            field_cmp("out_alpha",   e.alpha, d[151:135]);
            field_cmp("last",        e.last,  last);
        endfunction
    endclass

    // ------------------------------------------------------------------------
    // signals
    // ------------------------------------------------------------------------
    logic                          clk;
    logic                          rst_n;
    logic                          psel, penable, pwrite;
    logic [ppu_pkg::ADDR_W-1:0]    paddr;
    logic [31:0]                   pwdata;
    logic [31:0]                   prdata;
    logic                          pready;
    logic                          s_axis_tvalid, s_axis_tready;
    // spawn_x, spawn_y, spawn_z, spawn_size, vx, vy, vz
    logic [ppu_pkg::S_DATA_W-1:0]  s_axis_tdata;
    logic                          s_axis_tuser;   // kind
    logic                          m_axis_tvalid, m_axis_tready;
    // accepted, slot, x, y, z, size, alpha
    logic [ppu_pkg::M_DATA_W-1:0]  m_axis_tdata;
    logic [1:0]                    m_axis_tuser;   // result_kind
    logic                          m_axis_tlast;

    pool_scoreboard sb;
    int             idle_max;        // 0 gives back-to-back stretches
    bit             long_hold_req;   // asks the receiver for one long stall
    int             quiet_cycles;

    particle_pool_update dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .m_axis_tlast  (m_axis_tlast)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    // ------------------------------------------------------------------------
    // monitors: both sides sampled at the edge where the transfer happens
    // ------------------------------------------------------------------------
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
            sb.note_item(s_axis_tuser, s_axis_tdata);
        if (rst_n && m_axis_tvalid && m_axis_tready)
            sb.check_result(m_axis_tuser, m_axis_tdata, m_axis_tlast);
    end

    // watchdog on cycles with no transfer on either stream
    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= QUIET_LIMIT) begin
            $display("%0t watchdog: no transfer for %0d cycles", $time, QUIET_LIMIT);
            $display("TEST FAILED");
            $finish;
        end
    end

    // ------------------------------------------------------------------------
    // result side: random stalls, plus one long hold on request
    // ------------------------------------------------------------------------
    initial
    begin
        int gap;
        m_axis_tready <= 1'b0;
        @(posedge rst_n);
        forever begin
            if (long_hold_req) begin
                long_hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (LONG_HOLD) @(posedge clk);
            end
            else begin
                gap = $urandom_range(0, idle_max);
                if (gap > 0) begin
                    m_axis_tready <= 1'b0;
                    repeat (gap) @(posedge clk);
                end
            end
            m_axis_tready <= 1'b1;
            do @(posedge clk); while (!(m_axis_tvalid && m_axis_tready));
        end
    end

    // ------------------------------------------------------------------------
    // driver tasks
    // ------------------------------------------------------------------------
    task automatic reg_write(logic [2:0] idx, logic [31:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do @(posedge clk); while (!pready);
        sb.write_reg(idx, value);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_regs(int unsigned life, int unsigned win, int unsigned step,
                            int unsigned dh, int unsigned dv);
        reg_write(ppu_pkg::REG_INITIAL_LIFE, life);
        reg_write(ppu_pkg::REG_FADE_WINDOW,  win);
        reg_write(ppu_pkg::REG_FADE_STEP,    step);
        reg_write(ppu_pkg::REG_DAMP_H,       dh);
        reg_write(ppu_pkg::REG_DAMP_V,       dv);
    endtask

    // every kind of item ends in a result, so an empty queue means idle; the
    // first edge lets the monitor note the last transfer
    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (sb.pending.size() != 0)
            @(posedge clk);
        repeat (20) @(posedge clk);
    endtask

    task automatic send_item(logic kind, logic [ppu_pkg::S_DATA_W-1:0] data);
        int gap;
        gap = $urandom_range(0, idle_max);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= kind;
        s_axis_tdata  <= data;
        do @(posedge clk); while (!(s_axis_tvalid && s_axis_tready));
    endtask

    task automatic spawn(logic [31:0] x, logic [31:0] y, logic [31:0] z, logic [31:0] sz,
                         int vx, int vy, int vz);
        logic [ppu_pkg::S_DATA_W-1:0] d;
        d = '0;
        d[31:0]    = x;
        d[63:32]   = y;
        d[95:64]   = z;
        d[127:96]  = sz;
        d[146:128] = vx[18:0];
        d[165:147] = vy[18:0];
        d[184:166] = vz[18:0];
        send_item(ppu_pkg::KIND_SPAWN, d);
    endtask

    // ticks carry random junk in tdata, which the block must ignore
    task automatic tick();
        logic [ppu_pkg::S_DATA_W-1:0] d;
        d = {$urandom, $urandom, $urandom, $urandom, $urandom, $urandom};
        send_item(ppu_pkg::KIND_TICK, d);
    endtask

    function automatic int rand_vel();
        return int'($urandom_range(0, 262144)) - 131072;
    endfunction

    task automatic rand_spawn();
        spawn($urandom, $urandom, $urandom, $urandom, rand_vel(), rand_vel(), rand_vel());
    endtask

    // mostly spawn/tick mixes with random content
    task automatic rand_items(int count, int spawn_pct);
        for (int i = 0; i < count; i++) begin
            if ($urandom_range(1, 100) <= spawn_pct)
                rand_spawn();
            else
                tick();
        end
    endtask

    // ------------------------------------------------------------------------
    // main sequence
    // ------------------------------------------------------------------------
    initial
    begin
        sb = new();
        sb.clear_pool();
        idle_max      = 14;
        long_hold_req = 1'b0;
        quiet_cycles  = 0;
        rst_n         <= 1'b0;
        psel          <= 1'b0;
        penable       <= 1'b0;
        pwrite        <= 1'b0;
        paddr         <= '0;
        pwdata        <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tuser  <= ppu_pkg::KIND_SPAWN;
        s_axis_tdata  <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // directed: empty tick, field extremes, position saturation both ways
        tick();
        spawn(32'h7fff_fffb, 32'h8000_0005, 32'h0, 32'hffff_ffff, 131072, -131072, 0);
        spawn(32'h0, 32'hffff_ffff, 32'h8000_0000, 32'h0, -1, 1, -131072);
        spawn(32'h7fff_ffff, 32'h0, 32'h7fff_ffff, 32'h0001_0000, -131072, 131072, 131072);
        tick();
        tick();
        drain();

        // short life, fade every tick, alpha clipped at zero, damping extremes
        set_regs(2, 65535, 40000, 0, 65536);
        spawn(32'h1234_5678, 32'h8000_0000, 32'hffff_0000, 32'h5555_aaaa, 131072, -131072, 7);
        spawn(32'h0, 32'h0, 32'h0, 32'haaaa_5555, -5, 5, -131072);
        tick();
        spawn(32'h7fff_ffff, 32'h7fff_fff0, 32'h8000_0000, 32'h1, 3, 131072, -3);
        tick();
        tick();
        tick();
        drain();

        // random phase at reset values
        set_regs(180, 20, 3277, 62259, 64225);
        rand_items(25, 55);
        idle_max = 0;
        rand_items(10, 55);
        drain();

        idle_max = 14;
        set_regs(4, 65535, 65536, 65536, 0);
        rand_items(20, 50);
        drain();

        // one-tick life: every spawn is gone at the next tick
        set_regs(1, 1, 1, 1, 1);
        rand_items(14, 50);
        drain();

        set_regs(30, 25, 12345, $urandom_range(0, 65536), $urandom_range(0, 65536));
        rand_items(20, 50);
        drain();

        // fill the pool to overflow while the result side holds off
        set_regs(65535, 0, 0, 0, 65536);
        long_hold_req = 1'b1;
        idle_max = 0;
        for (int i = 0; i < 66; i++)
            rand_spawn();
        idle_max = 14;
        tick();
        rand_items(6, 60);
        tick();
        drain();

        $display("covered %0d placed spawns, %0d refused on a full pool, %0d empty ticks",
                 sb.spawns_ok, sb.spawns_full, sb.empty_ticks);
        $display("checked %0d results against the predicted pool", sb.results_seen);
        if (sb.errors == 0 && sb.pending.size() == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
